// File: hw/rtl/stt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Token kinds, error codes, field widths and the result record.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int KeywordBytes = 8;
  localparam int LengthBits   = 16;
  localparam int LineBits     = 16;
  localparam int KindBits     = 6;
  localparam int ErrBits      = 3;
  localparam int OffsetBits   = 32;
  localparam int MaxResults   = 3;

  localparam logic [KindBits-1:0] K_ERROR = 6'd0, K_IDENT = 6'd1, K_AND = 6'd2,
    K_CLASS = 6'd3, K_CONTINUE = 6'd4, K_BREAK = 6'd5, K_ELSE = 6'd6, K_FUN = 6'd7,
    K_VAR = 6'd8, K_LAMBDA = 6'd9, K_FALSE = 6'd10, K_FOR = 6'd11, K_IF = 6'd12,
    K_USE = 6'd13, K_OR = 6'd14, K_PRINT = 6'd15, K_RETURN = 6'd16, K_THIS = 6'd17,
    K_TRUE = 6'd18, K_WHILE = 6'd19, K_NUMBER = 6'd20, K_STRING = 6'd21,
    K_EOF = 6'd22, K_LPAREN = 6'd23, K_RPAREN = 6'd24, K_LBRACE = 6'd25,
    K_RBRACE = 6'd26, K_LBRACK = 6'd27, K_RBRACK = 6'd28, K_SEMI = 6'd29,
    K_COMMA = 6'd30, K_DOT = 6'd31, K_SLASH = 6'd32, K_COLON = 6'd33,
    K_MOD = 6'd34, K_BAND = 6'd35, K_BOR = 6'd36, K_INC = 6'd37, K_PLUS = 6'd38,
    K_DEC = 6'd39, K_ARROW = 6'd40, K_MINUS = 6'd41, K_NE = 6'd42, K_BANG = 6'd43,
    K_POW = 6'd44, K_STAR = 6'd45, K_EQEQ = 6'd46, K_EQ = 6'd47, K_LE = 6'd48,
    K_LT = 6'd49, K_GE = 6'd50, K_GT = 6'd51;

  localparam logic [ErrBits-1:0] E_NONE = 3'd0, E_HEX = 3'd1, E_OCT = 3'd2,
    E_STRING = 3'd3, E_CHAR = 3'd4;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  typedef struct packed {
    logic [KindBits-1:0]   kind;
    logic [ErrBits-1:0]    error_code;
    logic [OffsetBits-1:0] start_offset;
    logic [LengthBits-1:0] lexeme_length;
    logic [LineBits-1:0]   line_number;
    logic                  last_of_run;
  } token_t;

  typedef struct packed {
    logic                  action;
    logic [7:0]            char_in;
  } src_t;

  typedef logic [KeywordBytes-1:0][7:0] kwbuf_t;

  // Fixed parallel keyword match; length above the buffer is never a keyword.
  function automatic logic [KindBits-1:0] keyword_kind(input kwbuf_t b,
                                                       input logic [LengthBits-1:0] n);
    logic [KindBits-1:0] k;
    k = K_IDENT;
    case (n)
      16'd2: begin
        if (b[0] == "i" && b[1] == "f") k = K_IF;
        if (b[0] == "o" && b[1] == "r") k = K_OR;
      end
      16'd3: begin
        if ({b[0], b[1], b[2]} == "and") k = K_AND;
        if ({b[0], b[1], b[2]} == "let") k = K_VAR;
        if ({b[0], b[1], b[2]} == "for") k = K_FOR;
        if ({b[0], b[1], b[2]} == "use") k = K_USE;
      end
      16'd4: begin
        if ({b[0], b[1], b[2], b[3]} == "else") k = K_ELSE;
        if ({b[0], b[1], b[2], b[3]} == "this") k = K_THIS;
        if ({b[0], b[1], b[2], b[3]} == "true") k = K_TRUE;
      end
      16'd5: begin
        if ({b[0], b[1], b[2], b[3], b[4]} == "class") k = K_CLASS;
        if ({b[0], b[1], b[2], b[3], b[4]} == "break") k = K_BREAK;
        if ({b[0], b[1], b[2], b[3], b[4]} == "false") k = K_FALSE;
        if ({b[0], b[1], b[2], b[3], b[4]} == "print") k = K_PRINT;
        if ({b[0], b[1], b[2], b[3], b[4]} == "while") k = K_WHILE;
      end
      16'd6: begin
        if ({b[0], b[1], b[2], b[3], b[4], b[5]} == "define") k = K_FUN;
        if ({b[0], b[1], b[2], b[3], b[4], b[5]} == "lambda") k = K_LAMBDA;
        if ({b[0], b[1], b[2], b[3], b[4], b[5]} == "return") k = K_RETURN;
      end
      16'd8: begin
        if ({b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]} == "continue")
          k = K_CONTINUE;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/stt_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_stream_if: valid/ready channel
// Carries one payload of a given type per beat.
// ----------------------------------------------------------------------------
interface stt_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/stt_lexer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_lexer: scan state and token recognition
// Consumes one byte per step and produces up to three tokens for it.
// ----------------------------------------------------------------------------
module stt_lexer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire stt_pkg::src_t       item,
  output stt_pkg::token_t [2:0]    toks,
  output logic [1:0]               tok_count
);

  typedef enum logic [4:0] {
    M_IDLE, M_IDENT, M_H_US, M_H_X, M_O_US, M_O_O, M_INT, M_DOT, M_FRAC,
    M_HEX1, M_HEXN, M_OCT1, M_OCTN, M_STRING, M_COMMENT, M_SLASH, M_OP
  } mode_t;

  localparam logic [stt_pkg::LengthBits-1:0] LenTop = '1;
  localparam logic [stt_pkg::LineBits-1:0]   LineTop = '1;

  mode_t                             scan_mode, scan_mode_next;
  logic [7:0]                        pending_char, pending_char_next;
  logic [7:0]                        quote_char, quote_char_next;
  stt_pkg::kwbuf_t                   keyword_buffer, keyword_buffer_next;
  logic [stt_pkg::OffsetBits-1:0]    token_start, token_start_next;
  logic [stt_pkg::LengthBits-1:0]    token_length, token_length_next;
  logic [stt_pkg::LineBits-1:0]      line_count, line_count_next;
  logic [stt_pkg::OffsetBits-1:0]    byte_offset, byte_offset_next;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction
  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") || c == "_";
  endfunction
  function automatic logic is_oct(input logic [7:0] c);
    return (c >= "0" && c <= "7") || c == "_";
  endfunction
  function automatic logic [stt_pkg::LengthBits-1:0] sat_inc(
      input logic [stt_pkg::LengthBits-1:0] v);
    return (v == LenTop) ? v : v + 1'b1;
  endfunction
  function automatic logic [stt_pkg::KindBits-1:0] op_single(input logic [7:0] op);
    logic [stt_pkg::KindBits-1:0] k;
    case (op)
      "+":     k = stt_pkg::K_PLUS;
      "-":     k = stt_pkg::K_MINUS;
      "!":     k = stt_pkg::K_BANG;
      "*":     k = stt_pkg::K_STAR;
      "=":     k = stt_pkg::K_EQ;
      "<":     k = stt_pkg::K_LT;
      default: k = stt_pkg::K_GT;
    endcase
    return k;
  endfunction

  // Token kind of the open identifier.
  logic [stt_pkg::KindBits-1:0] ident_kind;
  assign ident_kind = (token_length > stt_pkg::LengthBits'(stt_pkg::KeywordBytes)) ?
                      stt_pkg::K_IDENT : stt_pkg::keyword_kind(keyword_buffer, token_length);

  // Number prefix modes fold through to the integer check; resolve that first.
  mode_t      num_mode;
  logic [7:0] c;
  assign c = item.char_in;

  always_comb begin
    num_mode = scan_mode;
    if (num_mode == M_H_US && !(c == "_" || c == "0" || c == "x" || c == "X"))
      num_mode = M_O_US;
    if (num_mode == M_H_X && !(c == "x" || c == "X")) num_mode = M_O_US;
    if (num_mode == M_O_US && !(c == "_" || c == "0" || c == "o" || c == "O"))
      num_mode = M_INT;
    if (num_mode == M_O_O && !(c == "o" || c == "O")) num_mode = M_INT;
  end

  // Build the tokens and next state for one beat.
  always_comb begin
    logic                         rescan;
    logic [stt_pkg::KindBits-1:0] k;
    logic [1:0]                   n;
    stt_pkg::token_t [2:0]        t;
    scan_mode_next      = scan_mode;
    pending_char_next   = pending_char;
    quote_char_next     = quote_char;
    keyword_buffer_next = keyword_buffer;
    token_start_next    = token_start;
    token_length_next   = token_length;
    line_count_next     = line_count;
    byte_offset_next    = byte_offset;
    rescan = 1'b0;
    k = stt_pkg::K_IDENT;
    n = 2'd0;
    t = '0;
    for (int i = 0; i < 3; i++) begin
      t[i].start_offset  = token_start;
      t[i].lexeme_length = token_length;
    end

    if (item.action == stt_pkg::ACT_END) begin
      case (scan_mode)
        M_IDENT: begin t[0].kind = ident_kind; n = 2'd1; end
        M_H_US, M_H_X, M_O_US, M_O_O, M_INT, M_FRAC, M_HEXN, M_OCTN: begin
          t[0].kind = stt_pkg::K_NUMBER; n = 2'd1;
        end
        M_DOT: begin
          t[0].kind = stt_pkg::K_NUMBER;
          t[1].kind = stt_pkg::K_DOT;
          t[1].start_offset = byte_offset - 1'b1;
          t[1].lexeme_length = 16'd1;
          n = 2'd2;
        end
        M_HEX1: begin t[0].error_code = stt_pkg::E_HEX; n = 2'd1; end
        M_OCT1: begin t[0].error_code = stt_pkg::E_OCT; n = 2'd1; end
        M_STRING: begin t[0].error_code = stt_pkg::E_STRING; n = 2'd1; end
        M_SLASH: begin
          t[0].kind = stt_pkg::K_SLASH; t[0].lexeme_length = 16'd1; n = 2'd1;
        end
        M_OP: begin
          t[0].kind = op_single(pending_char); t[0].lexeme_length = 16'd1; n = 2'd1;
        end
        default: n = 2'd0;
      endcase
      t[n].kind = stt_pkg::K_EOF;
      t[n].error_code = stt_pkg::E_NONE;
      t[n].start_offset = byte_offset;
      t[n].lexeme_length = '0;
      n = n + 2'd1;
      scan_mode_next      = M_IDLE;
      pending_char_next   = '0;
      quote_char_next     = '0;
      keyword_buffer_next = '0;
      token_start_next    = '0;
      token_length_next   = '0;
      line_count_next     = 16'd1;
      byte_offset_next    = '0;
    end else begin
      // Continue the open token.
      case (num_mode)
        M_IDLE: rescan = 1'b1;
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (token_length < stt_pkg::LengthBits'(stt_pkg::KeywordBytes))
              keyword_buffer_next[token_length[2:0]] = c;
            token_length_next = sat_inc(token_length);
          end else begin
            t[0].kind = ident_kind; n = 2'd1;
            scan_mode_next = M_IDLE; rescan = 1'b1;
          end
        end
        M_H_US: begin
          token_length_next = sat_inc(token_length);
          if (c == "0") scan_mode_next = M_H_X;
          else if (c == "x" || c == "X") scan_mode_next = M_HEX1;
        end
        M_H_X: begin
          token_length_next = sat_inc(token_length); scan_mode_next = M_HEX1;
        end
        M_O_US: begin
          token_length_next = sat_inc(token_length);
          if (c == "0") scan_mode_next = M_O_O;
          else if (c == "o" || c == "O") scan_mode_next = M_OCT1;
          else scan_mode_next = M_O_US;
        end
        M_O_O: begin
          token_length_next = sat_inc(token_length); scan_mode_next = M_OCT1;
        end
        M_INT: begin
          if (is_digit(c)) begin
            token_length_next = sat_inc(token_length); scan_mode_next = M_INT;
          end else if (c == ".") begin
            pending_char_next = c; scan_mode_next = M_DOT;
          end else begin
            t[0].kind = stt_pkg::K_NUMBER; n = 2'd1;
            scan_mode_next = M_IDLE; rescan = 1'b1;
          end
        end
        M_DOT: begin
          if (is_digit(c)) begin
            token_length_next = sat_inc(sat_inc(token_length)); scan_mode_next = M_FRAC;
          end else begin
            t[0].kind = stt_pkg::K_NUMBER;
            t[1].kind = stt_pkg::K_DOT;
            t[1].start_offset = byte_offset - 1'b1;
            t[1].lexeme_length = 16'd1;
            n = 2'd2; scan_mode_next = M_IDLE; rescan = 1'b1;
          end
        end
        M_FRAC, M_HEXN, M_OCTN: begin
          if ((num_mode == M_FRAC && is_digit(c)) || (num_mode == M_HEXN && is_hex(c)) ||
              (num_mode == M_OCTN && is_oct(c))) begin
            token_length_next = sat_inc(token_length);
          end else begin
            t[0].kind = stt_pkg::K_NUMBER; n = 2'd1;
            scan_mode_next = M_IDLE; rescan = 1'b1;
          end
        end
        M_HEX1: begin
          if (is_hex(c)) begin
            token_length_next = sat_inc(token_length); scan_mode_next = M_HEXN;
          end else begin
            t[0].error_code = stt_pkg::E_HEX; n = 2'd1;
            scan_mode_next = M_IDLE; rescan = 1'b1;
          end
        end
        M_OCT1: begin
          if (is_oct(c)) begin
            token_length_next = sat_inc(token_length); scan_mode_next = M_OCTN;
          end else begin
            t[0].error_code = stt_pkg::E_OCT; n = 2'd1;
            scan_mode_next = M_IDLE; rescan = 1'b1;
          end
        end
        M_STRING: begin
          token_length_next = sat_inc(token_length);
          if (c == quote_char) begin
            t[0].kind = stt_pkg::K_STRING;
            t[0].lexeme_length = sat_inc(token_length);
            n = 2'd1; scan_mode_next = M_IDLE;
          end else if (c == "\n" && line_count != LineTop) begin
            line_count_next = line_count + 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == "\n") begin scan_mode_next = M_IDLE; rescan = 1'b1; end
        end
        M_SLASH: begin
          if (c == "/") scan_mode_next = M_COMMENT;
          else begin
            t[0].kind = stt_pkg::K_SLASH; t[0].lexeme_length = 16'd1; n = 2'd1;
            scan_mode_next = M_IDLE; rescan = 1'b1;
          end
        end
        M_OP: begin
          scan_mode_next = M_IDLE;
          k = stt_pkg::K_ERROR;
          case (pending_char)
            "+": if (c == "+") k = stt_pkg::K_INC;
            "-": if (c == "-") k = stt_pkg::K_DEC; else if (c == ">") k = stt_pkg::K_ARROW;
            "!": if (c == "=") k = stt_pkg::K_NE;
            "*": if (c == "*") k = stt_pkg::K_POW;
            "=": if (c == "=") k = stt_pkg::K_EQEQ;
            "<": if (c == "=") k = stt_pkg::K_LE;
            default: if (c == "=") k = stt_pkg::K_GE;
          endcase
          n = 2'd1;
          if (k != stt_pkg::K_ERROR) begin
            t[0].kind = k; t[0].lexeme_length = 16'd2;
          end else begin
            t[0].kind = op_single(pending_char); t[0].lexeme_length = 16'd1;
            rescan = 1'b1;
          end
        end
        default: begin scan_mode_next = M_IDLE; rescan = 1'b1; end
      endcase

      // Start a fresh token on this byte.
      if (rescan) begin
        token_start_next  = byte_offset;
        token_length_next = 16'd1;
        k = stt_pkg::K_ERROR;
        if (c == " " || c == "\r" || c == "\t") begin
          k = stt_pkg::K_ERROR;
        end else if (c == "\n") begin
          if (line_count_next != LineTop) line_count_next = line_count_next + 1'b1;
        end else if (is_alpha(c)) begin
          keyword_buffer_next[0] = c; scan_mode_next = M_IDENT;
        end else if (is_digit(c)) begin
          scan_mode_next = M_H_US;
        end else begin
          case (c)
            "/": scan_mode_next = M_SLASH;
            "\"", "'": begin quote_char_next = c; scan_mode_next = M_STRING; end
            "+", "-", "!", "*", "=", "<", ">": begin
              pending_char_next = c; scan_mode_next = M_OP;
            end
            "(": k = stt_pkg::K_LPAREN;
            ")": k = stt_pkg::K_RPAREN;
            "{": k = stt_pkg::K_LBRACE;
            "}": k = stt_pkg::K_RBRACE;
            "[": k = stt_pkg::K_LBRACK;
            "]": k = stt_pkg::K_RBRACK;
            ";": k = stt_pkg::K_SEMI;
            ",": k = stt_pkg::K_COMMA;
            ".": k = stt_pkg::K_DOT;
            ":": k = stt_pkg::K_COLON;
            "%": k = stt_pkg::K_MOD;
            "&": k = stt_pkg::K_BAND;
            "|": k = stt_pkg::K_BOR;
            default: k = stt_pkg::K_ERROR;
          endcase
          if (!(c == "/" || c == "\"" || c == "'" || c == "+" || c == "-" || c == "!" ||
                c == "*" || c == "=" || c == "<" || c == ">")) begin
            t[n].kind = k;
            t[n].error_code = (k == stt_pkg::K_ERROR) ? stt_pkg::E_CHAR : stt_pkg::E_NONE;
            t[n].start_offset = byte_offset;
            t[n].lexeme_length = 16'd1;
            n = n + 2'd1;
          end
        end
      end
      byte_offset_next = byte_offset + 1'b1;
    end

    // Line number as seen at emission; string close never touches the count.
    for (int i = 0; i < 3; i++) begin
      t[i].line_number = line_count;
      t[i].last_of_run = (n == 2'(i + 1));
    end
    toks = t;
    tok_count = n;
  end

  // Hold scan state; advance on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= M_IDLE;
      pending_char   <= '0;
      quote_char     <= '0;
      keyword_buffer <= '0;
      token_start    <= '0;
      token_length   <= '0;
      line_count     <= 16'd1;
      byte_offset    <= '0;
    end else if (step) begin
      scan_mode      <= scan_mode_next;
      pending_char   <= pending_char_next;
      quote_char     <= quote_char_next;
      keyword_buffer <= keyword_buffer_next;
      token_start    <= token_start_next;
      token_length   <= token_length_next;
      line_count     <= line_count_next;
      byte_offset    <= byte_offset_next;
    end
  end

`ifndef SYNTH
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst) line_count != '0)
    else $error("line count reached zero");
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    step && item.action == stt_pkg::ACT_END |=> byte_offset == '0 && scan_mode == M_IDLE)
    else $error("end beat did not reset scan state");
  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    item.action == stt_pkg::ACT_END |-> tok_count != 2'd0)
    else $error("end beat without EOF");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/stt_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_out_queue: result buffer
// Holds up to eight tokens and drains them one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module stt_out_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire stt_pkg::token_t [2:0] toks,
  input  wire logic [1:0]            tok_count,
  output logic                       room,
  stt_stream_if.source               out
);

  localparam int Depth = 8;

  stt_pkg::token_t slots [Depth];
  logic [2:0] rd_ptr, wr_ptr;
  logic [3:0] fill, fill_next;
  logic       pop;

  assign pop       = out.valid && out.ready;
  assign out.valid = fill != '0;
  assign out.data  = slots[rd_ptr];
  // Room for a full beat of results even while draining slowly.
  assign room      = fill <= 4'(Depth - stt_pkg::MaxResults);
  assign fill_next = fill + (push ? {2'b00, tok_count} : 4'd0) - {3'b000, pop};

  // Write up to three results, advance pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < tok_count) slots[wr_ptr + 3'(i)] <= toks[i];
        end
        wr_ptr <= wr_ptr + {1'b0, tok_count};
      end
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill_next;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) fill <= 4'(Depth))
    else $error("result buffer overflow");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    3'(wr_ptr - rd_ptr) == fill[2:0])
    else $error("pointers disagree with fill");
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> room)
    else $error("push without room");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/source_text_tokenizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_text_tokenizer_core: streaming source lexer
// Takes one source byte per beat and emits tokens through a result buffer.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the buffer has room; a beat may produce
//   up to three tokens, which drain one per cycle from an eight-entry buffer
//   while the receiver is ready, so the input stalls only when the buffer
//   holds more than five.
// Reset: synchronous rst clears scan state (line 1, offset 0) and empties buffer.
module source_text_tokenizer_core (
  input  wire logic     clk,
  input  wire logic     rst,
  stt_stream_if.sink    src,
  stt_stream_if.source  tok
);

  stt_pkg::token_t [2:0] toks;
  logic [1:0]            tok_count;
  logic                  room;
  logic                  step;

  assign src.ready = room;
  assign step      = src.valid && src.ready;

  // Scan the byte.
  stt_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (src.data),
    .toks      (toks),
    .tok_count (tok_count)
  );

  // Queue results.
  stt_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .toks      (toks),
    .tok_count (tok_count),
    .room      (room),
    .out       (tok)
  );

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: token stream check of source_text_tokenizer_core
// Feeds source bytes and end marks, predicts the token stream with an
// in-bench lexer, and compares every token beat field by field.
// ----------------------------------------------------------------------------
module tb_top;

  typedef enum logic [4:0] {
    S_IDLE, S_IDENT, S_H_US, S_H_X, S_O_US, S_O_O, S_INT, S_DOT, S_FRAC,
    S_HEX1, S_HEXN, S_OCT1, S_OCTN, S_STRING, S_COMMENT, S_SLASH, S_OP
  } scan_e;

  // Lexer model plus the queue of tokens still owed by the block
  class token_scoreboard;
    scan_e           mode;
    logic [7:0]      op_char, quote;
    logic [7:0]      kw [stt_pkg::KeywordBytes];
    logic [31:0]     tstart, tlen, line, offset;
    stt_pkg::token_t owed [$];
    stt_pkg::token_t batch [$];
    int              errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode = S_IDLE;
      op_char = 0;
      quote = 0;
      foreach (kw[i]) kw[i] = 0;
      tstart = 0;
      tlen = 0;
      line = 1;
      offset = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function bit alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit hexd(logic [7:0] c);
      return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") || c == "_";
    endfunction

    function bit octd(logic [7:0] c);
      return (c >= "0" && c <= "7") || c == "_";
    endfunction

    function void put(logic [stt_pkg::KindBits-1:0] k, logic [stt_pkg::ErrBits-1:0] e,
                      logic [31:0] st, logic [31:0] n);
      stt_pkg::token_t t;
      if (batch.size() >= stt_pkg::MaxResults) return;
      t.kind = k;
      t.error_code = e;
      t.start_offset = st;
      t.lexeme_length = n[stt_pkg::LengthBits-1:0];
      t.line_number = line[stt_pkg::LineBits-1:0];
      t.last_of_run = 1'b0;
      batch.push_back(t);
    endfunction

    function void put_lexeme(logic [stt_pkg::KindBits-1:0] k);
      put(k, stt_pkg::E_NONE, tstart, tlen);
    endfunction

    function void grow();
      if (tlen < (1 << stt_pkg::LengthBits) - 1) tlen++;
    endfunction

    function logic [stt_pkg::KindBits-1:0] word_kind();
      string s;
      s = "";
      if (tlen > stt_pkg::KeywordBytes) return stt_pkg::K_IDENT;
      for (int i = 0; i < tlen; i++) s = {s, string'(kw[i])};
      case (s)
        "and": return stt_pkg::K_AND;
        "class": return stt_pkg::K_CLASS;
        "continue": return stt_pkg::K_CONTINUE;
        "break": return stt_pkg::K_BREAK;
        "else": return stt_pkg::K_ELSE;
        "define": return stt_pkg::K_FUN;
        "let": return stt_pkg::K_VAR;
        "lambda": return stt_pkg::K_LAMBDA;
        "false": return stt_pkg::K_FALSE;
        "for": return stt_pkg::K_FOR;
        "if": return stt_pkg::K_IF;
        "use": return stt_pkg::K_USE;
        "or": return stt_pkg::K_OR;
        "print": return stt_pkg::K_PRINT;
        "return": return stt_pkg::K_RETURN;
        "this": return stt_pkg::K_THIS;
        "true": return stt_pkg::K_TRUE;
        "while": return stt_pkg::K_WHILE;
        default: return stt_pkg::K_IDENT;
      endcase
    endfunction

    // Two-character operator, or K_ERROR when the pair does not combine
    function logic [stt_pkg::KindBits-1:0] op_two(logic [7:0] c);
      case (op_char)
        "+": return c == "+" ? stt_pkg::K_INC : stt_pkg::K_ERROR;
        "-": return c == "-" ? stt_pkg::K_DEC :
                    (c == ">" ? stt_pkg::K_ARROW : stt_pkg::K_ERROR);
        "*": return c == "*" ? stt_pkg::K_POW : stt_pkg::K_ERROR;
        default: return c == "=" ? (op_char == "!" ? stt_pkg::K_NE :
                                    op_char == "=" ? stt_pkg::K_EQEQ :
                                    op_char == "<" ? stt_pkg::K_LE : stt_pkg::K_GE) :
                                   stt_pkg::K_ERROR;
      endcase
    endfunction

    function logic [stt_pkg::KindBits-1:0] op_one();
      case (op_char)
        "+": return stt_pkg::K_PLUS;
        "-": return stt_pkg::K_MINUS;
        "!": return stt_pkg::K_BANG;
        "*": return stt_pkg::K_STAR;
        "=": return stt_pkg::K_EQ;
        "<": return stt_pkg::K_LT;
        default: return stt_pkg::K_GT;
      endcase
    endfunction

    function void number_then_dot();
      put_lexeme(stt_pkg::K_NUMBER);
      put(stt_pkg::K_DOT, stt_pkg::E_NONE, offset - 1, 1);
    endfunction

    // Offer a byte to the open lexeme; return 1 when it must be scanned afresh
    function bit extend(logic [7:0] c);
      logic [stt_pkg::KindBits-1:0] k;
      forever begin
        case (mode)
          S_IDENT: begin
            if (alpha(c) || digit(c)) begin
              if (tlen < stt_pkg::KeywordBytes) kw[tlen] = c;
              grow();
              return 0;
            end
            put_lexeme(word_kind());
            mode = S_IDLE;
            return 1;
          end
          S_H_US: begin
            if (c == "_") begin grow(); return 0; end
            if (c == "0") begin grow(); mode = S_H_X; return 0; end
            if (c == "x" || c == "X") begin grow(); mode = S_HEX1; return 0; end
            mode = S_O_US;
          end
          S_H_X: begin
            if (c == "x" || c == "X") begin grow(); mode = S_HEX1; return 0; end
            mode = S_O_US;
          end
          S_O_US: begin
            if (c == "_") begin grow(); return 0; end
            if (c == "0") begin grow(); mode = S_O_O; return 0; end
            if (c == "o" || c == "O") begin grow(); mode = S_OCT1; return 0; end
            mode = S_INT;
          end
          S_O_O: begin
            if (c == "o" || c == "O") begin grow(); mode = S_OCT1; return 0; end
            mode = S_INT;
          end
          S_INT: begin
            if (digit(c)) begin grow(); return 0; end
            if (c == ".") begin op_char = c; mode = S_DOT; return 0; end
            put_lexeme(stt_pkg::K_NUMBER);
            mode = S_IDLE;
            return 1;
          end
          S_DOT: begin
            if (digit(c)) begin grow(); grow(); mode = S_FRAC; return 0; end
            number_then_dot();
            mode = S_IDLE;
            return 1;
          end
          S_FRAC, S_HEXN, S_OCTN: begin
            if ((mode == S_FRAC && digit(c)) || (mode == S_HEXN && hexd(c)) ||
                (mode == S_OCTN && octd(c))) begin
              grow();
              return 0;
            end
            put_lexeme(stt_pkg::K_NUMBER);
            mode = S_IDLE;
            return 1;
          end
          S_HEX1: begin
            if (hexd(c)) begin grow(); mode = S_HEXN; return 0; end
            put(stt_pkg::K_ERROR, stt_pkg::E_HEX, tstart, tlen);
            mode = S_IDLE;
            return 1;
          end
          S_OCT1: begin
            if (octd(c)) begin grow(); mode = S_OCTN; return 0; end
            put(stt_pkg::K_ERROR, stt_pkg::E_OCT, tstart, tlen);
            mode = S_IDLE;
            return 1;
          end
          S_STRING: begin
            grow();
            if (c == quote) begin
              put_lexeme(stt_pkg::K_STRING);
              mode = S_IDLE;
            end else if (c == "\n" && line < (1 << stt_pkg::LineBits) - 1) begin
              line++;
            end
            return 0;
          end
          S_COMMENT: begin
            if (c == "\n") begin mode = S_IDLE; return 1; end
            return 0;
          end
          S_SLASH: begin
            if (c == "/") begin mode = S_COMMENT; return 0; end
            put(stt_pkg::K_SLASH, stt_pkg::E_NONE, tstart, 1);
            mode = S_IDLE;
            return 1;
          end
          S_OP: begin
            k = op_two(c);
            mode = S_IDLE;
            if (k != stt_pkg::K_ERROR) begin
              put(k, stt_pkg::E_NONE, tstart, 2);
              return 0;
            end
            put(op_one(), stt_pkg::E_NONE, tstart, 1);
            return 1;
          end
          default: begin
            mode = S_IDLE;
            return 1;
          end
        endcase
      end
    endfunction

    function void begin_lexeme(logic [7:0] c);
      logic [stt_pkg::KindBits-1:0] k;
      tstart = offset;
      tlen = 1;
      if (c == " " || c == "\r" || c == "\t") return;
      if (c == "\n") begin
        if (line < (1 << stt_pkg::LineBits) - 1) line++;
        return;
      end
      if (alpha(c)) begin kw[0] = c; mode = S_IDENT; return; end
      if (digit(c)) begin mode = S_H_US; return; end
      case (c)
        "/": begin mode = S_SLASH; return; end
        "\"", "'": begin quote = c; mode = S_STRING; return; end
        "+", "-", "!", "*", "=", "<", ">": begin op_char = c; mode = S_OP; return; end
        "(": k = stt_pkg::K_LPAREN;
        ")": k = stt_pkg::K_RPAREN;
        "{": k = stt_pkg::K_LBRACE;
        "}": k = stt_pkg::K_RBRACE;
        "[": k = stt_pkg::K_LBRACK;
        "]": k = stt_pkg::K_RBRACK;
        ";": k = stt_pkg::K_SEMI;
        ",": k = stt_pkg::K_COMMA;
        ".": k = stt_pkg::K_DOT;
        ":": k = stt_pkg::K_COLON;
        "%": k = stt_pkg::K_MOD;
        "&": k = stt_pkg::K_BAND;
        "|": k = stt_pkg::K_BOR;
        default: begin
          put(stt_pkg::K_ERROR, stt_pkg::E_CHAR, offset, 1);
          return;
        end
      endcase
      put(k, stt_pkg::E_NONE, offset, 1);
    endfunction

    function void flush();
      case (mode)
        S_IDENT: put_lexeme(word_kind());
        S_H_US, S_H_X, S_O_US, S_O_O, S_INT, S_FRAC, S_HEXN, S_OCTN:
          put_lexeme(stt_pkg::K_NUMBER);
        S_DOT: number_then_dot();
        S_HEX1: put(stt_pkg::K_ERROR, stt_pkg::E_HEX, tstart, tlen);
        S_OCT1: put(stt_pkg::K_ERROR, stt_pkg::E_OCT, tstart, tlen);
        S_STRING: put(stt_pkg::K_ERROR, stt_pkg::E_STRING, tstart, tlen);
        S_SLASH: put(stt_pkg::K_SLASH, stt_pkg::E_NONE, tstart, 1);
        S_OP: put(op_one(), stt_pkg::E_NONE, tstart, 1);
        default: ;
      endcase
    endfunction

    // Note an accepted input beat and queue the tokens it causes
    function void note(stt_pkg::src_t s);
      batch.delete();
      if (s.action == stt_pkg::ACT_END) begin
        flush();
        put(stt_pkg::K_EOF, stt_pkg::E_NONE, offset, 0);
        clear();
      end else begin
        if (extend(s.char_in)) begin_lexeme(s.char_in);
        offset++;
      end
      if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
      foreach (batch[i]) owed.push_back(batch[i]);
    endfunction

    function void field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, e, a);
        errors++;
      end
    endfunction

    // Check an accepted token beat against the oldest owed token
    function void check(stt_pkg::token_t t);
      stt_pkg::token_t e;
      if (owed.size() == 0) begin
        $display("%0t unexpected token: expected none actual %p", $realtime, t);
        errors++;
        return;
      end
      e = owed.pop_front();
      field("kind", e.kind, t.kind);
      field("error_code", e.error_code, t.error_code);
      field("start_offset", e.start_offset, t.start_offset);
      field("lexeme_length", e.lexeme_length, t.lexeme_length);
      field("line_number", e.line_number, t.line_number);
      field("last_of_run", e.last_of_run, t.last_of_run);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  int   tx_pct = 0;
  int   rx_pct = 0;
  int   hold_left = 0;
  bit   hold_req = 0;
  logic [7:0] bytes [$];
  token_scoreboard sb = new();

  stt_stream_if #(.payload_t(stt_pkg::src_t))   src ();
  stt_stream_if #(.payload_t(stt_pkg::token_t)) tok ();

  source_text_tokenizer_core dut (.clk(clk), .rst(rst), .src(src), .tok(tok));

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    src.valid = 0;
    src.data = '0;
    tok.ready = 0;
  end

  // Receiver hold-off: count one long stretch down once it is requested
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= 300;
      hold_req  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Token sink: check each beat, then pick the next ready, honoring a hold-off
  always @(posedge clk) begin
    if (rst) begin
      tok.ready <= 1'b0;
    end else begin
      if (tok.valid && tok.ready) sb.check(tok.data);
      if (hold_req || hold_left > 0) begin
        tok.ready <= 1'b0;
      end else begin
        tok.ready <= ($urandom_range(99) >= rx_pct);
      end
    end
  end

  task automatic send_beat(logic act, logic [7:0] ch);
    stt_pkg::src_t s;
    s.action = act;
    s.char_in = ch;
    while ($urandom_range(99) < tx_pct) begin
      src.valid <= 1'b0;
      @(posedge clk);
    end
    src.valid <= 1'b1;
    src.data <= s;
    do @(posedge clk); while (!src.ready);
    sb.note(s);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) bytes.push_back(s[i]);
  endtask

  // Append one random lexeme, mostly well formed, plus an optional separator
  task automatic push_lexeme();
    string words [18] = '{"and", "class", "continue", "break", "else", "define", "let",
                          "lambda", "false", "for", "if", "use", "or", "print", "return",
                          "this", "true", "while"};
    string ops [22] = '{"++", "+", "--", "->", "-", "!=", "!", "**", "*", "==", "=",
                        "<=", "<", ">=", ">", "(", ")", "{", "}", "[", "];", ",.:%&|"};
    string alnum;
    string hexch;
    string octch;
    int n;
    alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    hexch = "0123456789abcdefABCDEF_";
    octch = "012345678_";
    case ($urandom_range(10))
      0: push_text(words[$urandom_range(17)]);
      1: begin
        bytes.push_back(alnum[$urandom_range(52)]);
        n = $urandom_range(11);
        repeat (n) bytes.push_back(alnum[$urandom_range(62)]);
      end
      2: begin
        n = $urandom_range(1, 4);
        repeat (n) bytes.push_back("0" + $urandom_range(9));
        if ($urandom_range(2) == 0) bytes.push_back("_");
        if ($urandom_range(1)) begin
          bytes.push_back(".");
          if ($urandom_range(3) != 0) bytes.push_back("0" + $urandom_range(9));
        end
      end
      3: begin
        push_text($urandom_range(1) ? "0x" : "0X");
        n = $urandom_range(3);
        repeat (n) bytes.push_back(hexch[$urandom_range(22)]);
      end
      4: begin
        push_text($urandom_range(1) ? "0o" : "0O");
        n = $urandom_range(3);
        repeat (n) bytes.push_back(octch[$urandom_range(9)]);
      end
      5: begin
        n = $urandom_range(1) ? "\"" : "'";
        bytes.push_back(n);
        repeat ($urandom_range(4)) bytes.push_back($urandom_range(1) ? "q" : "\n");
        bytes.push_back(n);
      end
      6, 7: push_text(ops[$urandom_range(21)]);
      8: push_text("// note\n");
      9: bytes.push_back($urandom_range(255));
      default: bytes.push_back("/");
    endcase
    case ($urandom_range(4))
      0: bytes.push_back(" ");
      1: bytes.push_back("\n");
      2: bytes.push_back("\t");
      default: ;
    endcase
  endtask

  task automatic send_bytes();
    while (bytes.size() > 0) send_beat(stt_pkg::ACT_BYTE, bytes.pop_front());
  endtask

  task automatic drain();
    src.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Random source text, with end marks now and then
  task automatic random_phase(int beats);
    int sent;
    sent = 0;
    while (sent < beats) begin
      push_lexeme();
      sent += bytes.size();
      send_bytes();
      if ($urandom_range(9) == 0) begin
        send_beat(stt_pkg::ACT_END, 8'($urandom_range(255)));
        sent++;
      end
    end
    send_beat(stt_pkg::ACT_END, 8'h00);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: bad hex, bad octal, dot after number, operators, comment,
    // zero byte, then an unterminated string flushed by the end mark
    push_text("if 0x 0o8 1.a->!=//c\n");
    bytes.push_back(8'h00);
    bytes.push_back(8'hFF);
    push_text("\"s");
    send_bytes();
    send_beat(stt_pkg::ACT_END, 8'hFF);
    push_text("continuex 9.");
    send_bytes();
    send_beat(stt_pkg::ACT_END, 8'h00);
    drain();

    // No idling, with a long receiver hold-off that backs up the input
    hold_req = 1;
    random_phase(42);
    drain();

    tx_pct = 85;
    random_phase(42);
    drain();

    tx_pct = 0;
    rx_pct = 85;
    random_phase(42);
    drain();

    tx_pct = 19;
    rx_pct = 19;
    random_phase(42);
    drain();

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS source_text_tokenizer_core");
    end else begin
      $display("FAIL source_text_tokenizer_core");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL source_text_tokenizer_core");
    $finish;
  end

endmodule

// File: source_text_tokenizer_core.f
hw/rtl/stt_pkg.sv
hw/rtl/stt_stream_if.sv
hw/rtl/stt_lexer.sv
hw/rtl/stt_out_queue.sv
hw/rtl/source_text_tokenizer_core.sv
sim/tb_top.sv
